@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk / rst_n; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check only while out of reset
`define VUC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check at every edge, reset included
`define VUC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define VUC_ASSERT(lbl, prop, msg)
`define VUC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/vuc_pkg.sv @@
// ----------------------------------------------------------------------------
// vuc_pkg
// Types and codes of the utterance capture state machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vuc_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 1024;

  // phase codes
  localparam logic [2:0] PH_WARMUP     = 3'd0;
  localparam logic [2:0] PH_SETUP      = 3'd1;
  localparam logic [2:0] PH_SILENCE    = 3'd2;
  localparam logic [2:0] PH_PREDETECT  = 3'd3;
  localparam logic [2:0] PH_SPEECH     = 3'd4;
  localparam logic [2:0] PH_POSTDETECT = 3'd5;
  localparam logic [2:0] PH_DETECTED   = 3'd6;
  localparam logic [2:0] PH_UNUSED     = 3'd7;

  // status codes
  localparam logic [1:0] ST_LISTEN      = 2'd0;
  localparam logic [1:0] ST_DETECTED    = 2'd1;
  localparam logic [1:0] ST_FULL_SPEECH = 2'd2;
  localparam logic [1:0] ST_FULL_OTHER  = 2'd3;

  // buffer commands
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_STORE = 2'd1;
  localparam logic [1:0] ACT_SLIDE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_WARMUP   = 3'd0;
  localparam logic [2:0] CFG_PREROLL  = 3'd1;
  localparam logic [2:0] CFG_DECISION = 3'd2;
  localparam logic [2:0] CFG_HANGOVER = 3'd3;
  localparam logic [2:0] CFG_CAPACITY = 3'd4;

  typedef struct packed {
    logic mode;
    logic is_speech;
  } vuc_in_t;

  typedef struct packed {
    logic [2:0]  vad_phase;
    logic [1:0]  status;
    logic [10:0] sound_frames;
    logic [1:0]  buffer_action;
    logic [9:0]  write_index;
    logic [10:0] slide_frames;
  } vuc_out_t;

endpackage

@@ rtl/vuc_stream_if.sv @@
// ----------------------------------------------------------------------------
// vuc_stream_if
// Valid/ready request channel with a typed payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vuc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/vad_utterance_capture_fsm.sv @@
// ----------------------------------------------------------------------------
// vad_utterance_capture_fsm
// Utterance capture state machine driven by per-frame speech verdicts.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per audio frame, payload mode (1 = restart to warmup)
//            and is_speech (external classifier verdict).
//   out_ch : one result per request: phase, status, held frame count and the
//            buffer command (store at write_index, or drop slide_frames from
//            the front, then store).
//   cfg_*  : register writes; the user must see they are taken only while no
//            request is in flight, as the block itself has no check for it.
// Path: a request is captured in the input register, then evaluated against
//   the machine state into the result register, which drives out_ch.valid.
// Throughput: one request per cycle while out_ch takes its results; the input
//   register and the result register form a two-deep pipeline, and the state
//   update is a single pass of compare/increment logic.
// Reset: the machine returns to warmup with all counts cleared and the
//   registers take their defaults; both channels are empty.
// Stall: while out_ch is not taken the result holds, one more request waits
//   in the input register, then in_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vad_utterance_capture_fsm #(
  parameter int unsigned MAX_FRAMES = vuc_pkg::MAX_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vuc_stream_if.sink   in_ch,
  vuc_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [10:0] CapClamp = (MAX_FRAMES > 2047) ? 11'd2047 : 11'(MAX_FRAMES);

  logic [15:0] warmup_r, preroll_r, decision_r, hangover_r;
  logic [10:0] capacity_r;

  logic              s1_valid_r;
  vuc_pkg::vuc_in_t  s1_data_r;
  logic              out_valid_r;
  vuc_pkg::vuc_out_t out_data_r;
  logic              s1_advance;
  logic              s1_fire;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [10:0] cnt_r, cnt_nxt;
  logic        pre_r, pre_nxt;

  vuc_pkg::vuc_out_t res;
  logic [10:0] cap_lim;
  logic [15:0] pc_inc;
  logic        speech;
  logic [11:0] shift;
  logic [11:0] widx_w;

  assign s1_advance     = !out_valid_r || out_ch.ready;
  assign s1_fire        = s1_valid_r && s1_advance;
  assign in_ch.ready    = !s1_valid_r || s1_advance;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;
  assign cap_lim        = (capacity_r > CapClamp) ? CapClamp : capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r   <= 16'd10;
      preroll_r  <= 16'd10;
      decision_r <= 16'd5;
      hangover_r <= 16'd30;
      capacity_r <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        vuc_pkg::CFG_WARMUP:   warmup_r   <= cfg_wdata;
        vuc_pkg::CFG_PREROLL:  preroll_r  <= cfg_wdata;
        vuc_pkg::CFG_DECISION: decision_r <= cfg_wdata;
        vuc_pkg::CFG_HANGOVER: hangover_r <= cfg_wdata;
        vuc_pkg::CFG_CAPACITY: capacity_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    pre_nxt   = pre_r;
    res       = '0;
    shift     = '0;
    widx_w    = '0;
    pc_inc    = (pc_r != 16'hFFFF) ? pc_r + 16'd1 : pc_r;
    speech    = pre_r & s1_data_r.is_speech;
    if (s1_data_r.mode) begin
      phase_nxt  = vuc_pkg::PH_WARMUP;
      pc_nxt     = '0;
      cnt_nxt    = '0;
      pre_nxt    = 1'b0;
      res.status = vuc_pkg::ST_LISTEN;
    end else if (phase_r == vuc_pkg::PH_DETECTED) begin
      res.status = vuc_pkg::ST_DETECTED;
    end else if ({1'b0, cap_lim} < {1'b0, cnt_r} + 12'd1) begin
      res.status = (phase_r inside {[vuc_pkg::PH_SPEECH:vuc_pkg::PH_UNUSED]}) ?
                   vuc_pkg::ST_FULL_SPEECH : vuc_pkg::ST_FULL_OTHER;
    end else begin
      pc_nxt = pc_inc;
      case (phase_r)
        vuc_pkg::PH_WARMUP: begin
          if (pc_inc >= warmup_r) begin
            pc_nxt    = '0;
            phase_nxt = vuc_pkg::PH_SETUP;
          end
        end
        vuc_pkg::PH_SETUP: begin
          pc_nxt    = '0;
          phase_nxt = vuc_pkg::PH_SILENCE;
        end
        vuc_pkg::PH_SILENCE: begin
          if (!pre_r) begin
            cnt_nxt = cnt_r + 11'd1;
            if (pc_inc >= preroll_r) pre_nxt = 1'b1;
          end else if (speech) begin
            pc_nxt    = '0;
            cnt_nxt   = cnt_r + 11'd1;
            phase_nxt = vuc_pkg::PH_PREDETECT;
          end
        end
        vuc_pkg::PH_PREDETECT: begin
          if (speech) begin
            cnt_nxt = cnt_r + 11'd1;
            if (pc_inc >= decision_r) begin
              pc_nxt    = '0;
              phase_nxt = vuc_pkg::PH_SPEECH;
            end
          end else begin
            cnt_nxt   = ({5'd0, cnt_r} > pc_inc) ? cnt_r - pc_inc[10:0] : '0;
            pc_nxt    = '0;
            phase_nxt = vuc_pkg::PH_SILENCE;
          end
        end
        vuc_pkg::PH_SPEECH: begin
          cnt_nxt = cnt_r + 11'd1;
          if (!speech) begin
            pc_nxt    = '0;
            phase_nxt = vuc_pkg::PH_POSTDETECT;
          end
        end
        vuc_pkg::PH_POSTDETECT: begin
          cnt_nxt = cnt_r + 11'd1;
          if (speech) begin
            pc_nxt    = '0;
            phase_nxt = vuc_pkg::PH_SPEECH;
          end else if (pc_inc >= hangover_r) begin
            pc_nxt    = '0;
            phase_nxt = vuc_pkg::PH_DETECTED;
          end
        end
        vuc_pkg::PH_DETECTED: ;
        default: begin
          pc_nxt    = '0;
          cnt_nxt   = '0;
          phase_nxt = vuc_pkg::PH_WARMUP;
        end
      endcase
      if ({1'b0, cnt_r} + 12'd1 == {1'b0, cnt_nxt}) begin
        res.buffer_action = vuc_pkg::ACT_STORE;
        res.write_index   = cnt_r[9:0];
      end else if (phase_nxt == vuc_pkg::PH_SILENCE && cnt_r >= cnt_nxt) begin
        shift = {1'b0, cnt_r} - {1'b0, cnt_nxt} + 12'd1;
        if ({1'b0, cnt_r} > shift) begin
          widx_w            = {1'b0, cnt_r} - shift;
          res.buffer_action = vuc_pkg::ACT_SLIDE;
          res.slide_frames  = shift[10:0];
          res.write_index   = widx_w[9:0];
        end
      end
      res.status = (phase_nxt == vuc_pkg::PH_DETECTED) ?
                   vuc_pkg::ST_DETECTED : vuc_pkg::ST_LISTEN;
    end
    res.vad_phase    = phase_nxt;
    res.sound_frames = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= vuc_pkg::PH_WARMUP;
      pc_r        <= '0;
      cnt_r       <= '0;
      pre_r       <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s1_advance) out_valid_r <= s1_valid_r;
      if (s1_fire) begin
        phase_r <= phase_nxt;
        pc_r    <= pc_nxt;
        cnt_r   <= cnt_nxt;
        pre_r   <= pre_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) s1_data_r <= in_ch.payload;
    if (s1_fire) out_data_r <= res;
  end

  `VUC_ASSERT(a_phase_used, phase_r != vuc_pkg::PH_UNUSED, "unused phase code reached")
  `VUC_ASSERT(a_slide_in_silence, out_valid_r && out_data_r.buffer_action == vuc_pkg::ACT_SLIDE |-> out_data_r.vad_phase == vuc_pkg::PH_SILENCE, "slide outside silence")
  `VUC_ASSERT(a_full_no_action, out_valid_r && (out_data_r.status == vuc_pkg::ST_FULL_SPEECH || out_data_r.status == vuc_pkg::ST_FULL_OTHER) |-> out_data_r.buffer_action == vuc_pkg::ACT_NONE, "buffer command while full")
  `VUC_ASSERT(a_preroll_clear, $fell(pre_r) |-> $past(s1_fire && s1_data_r.mode), "pre-roll cleared without restart")

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Utterance capture machine regression: a directed plan walks restart,
// warmup, pre-roll fill, speech confirmation, hangover, detection and both
// buffer-full codes, then random verdict runs under changing register settings
// and handshake pressure. Each result is compared field by field against the
// plan's expected report or an in-bench model of the phase machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF    = 10;
  localparam int HOLD_LEN    = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 4;
  localparam int PLAN_LEN    = 35;

  localparam logic [2:0] CFG_SPARE = 3'd7;

  localparam vuc_pkg::vuc_in_t FRAME_QUIET   = '{mode: 1'b0, is_speech: 1'b0};
  localparam vuc_pkg::vuc_in_t FRAME_VOICE   = '{mode: 1'b0, is_speech: 1'b1};
  localparam vuc_pkg::vuc_in_t RESTART_QUIET = '{mode: 1'b1, is_speech: 1'b0};
  localparam vuc_pkg::vuc_in_t RESTART_VOICE = '{mode: 1'b1, is_speech: 1'b1};

  localparam vuc_pkg::vuc_out_t IDLE_ACK =
    '{vad_phase: vuc_pkg::PH_WARMUP, status: vuc_pkg::ST_LISTEN, default: '0};
  localparam vuc_pkg::vuc_out_t FULL_ACK =
    '{vad_phase: vuc_pkg::PH_WARMUP, status: vuc_pkg::ST_FULL_OTHER, default: '0};

  typedef struct {
    bit                reg_wr;
    logic [2:0]        reg_idx;
    logic [15:0]       reg_val;
    vuc_pkg::vuc_in_t  req;
    bit                typed;
    vuc_pkg::vuc_out_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  vuc_stream_if #(.payload_t(vuc_pkg::vuc_in_t))  in_if ();
  vuc_stream_if #(.payload_t(vuc_pkg::vuc_out_t)) out_if ();

  vad_utterance_capture_fsm uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register mirror
  int unsigned warmup_cfg   = 10;
  int unsigned preroll_cfg  = 10;
  int unsigned decision_cfg = 5;
  int unsigned hangover_cfg = 30;
  int unsigned capacity_cfg = 1024;

  // machine mirror
  logic [2:0]  phase_q      = vuc_pkg::PH_WARMUP;
  int unsigned pcount_q     = 0;
  int unsigned held_q       = 0;
  bit          preroll_ok_q = 1'b0;

  vuc_pkg::vuc_out_t frame_reports[$];

  int  mismatches   = 0;
  int  quiet_cycles = 0;
  int  stall_pct    = 0;
  int  hold_req     = 0;
  int  hold_seen    = 0;
  int  hold_left    = 0;
  int  run_left     = 0;
  bit  run_val      = 1'b0;

  // {reg_wr, reg_idx, reg_val, req, typed, want}
  plan_row_t plan [PLAN_LEN] = '{
    '{1'b1, vuc_pkg::CFG_CAPACITY, 16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b1, FULL_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b1, FULL_ACK},
    '{1'b1, vuc_pkg::CFG_WARMUP,   16'hFFFF, FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b1, vuc_pkg::CFG_CAPACITY, 16'd2047, FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b1, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    RESTART_VOICE, 1'b1, IDLE_ACK},
    '{1'b1, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b1, vuc_pkg::CFG_PREROLL,  16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b1, vuc_pkg::CFG_DECISION, 16'd1,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b1, vuc_pkg::CFG_HANGOVER, 16'd1,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b1, CFG_SPARE,             16'hFFFF, FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    RESTART_QUIET, 1'b1, IDLE_ACK},
    '{1'b1, vuc_pkg::CFG_CAPACITY, 16'd3,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_VOICE,   1'b0, IDLE_ACK},
    '{1'b0, vuc_pkg::CFG_WARMUP,   16'd0,    FRAME_QUIET,   1'b0, IDLE_ACK}
  };

  int send_idle_pct [4] = '{0, 48, 0, 38};
  int recv_stall_pct[4] = '{0, 0, 48, 38};

  always #CLK_HALF clk = ~clk;

  function automatic vuc_pkg::vuc_out_t capture_step(vuc_pkg::vuc_in_t r);
    vuc_pkg::vuc_out_t rep;
    int unsigned       cap;
    int unsigned       prev;
    int unsigned       shift;
    bit                speech;
    rep = '0;
    cap = (capacity_cfg > vuc_pkg::MAX_FRAMES_DEF) ? vuc_pkg::MAX_FRAMES_DEF : capacity_cfg;
    if (r.mode) begin
      phase_q = vuc_pkg::PH_WARMUP;
      pcount_q = 0;
      held_q = 0;
      preroll_ok_q = 1'b0;
    end else if (phase_q == vuc_pkg::PH_DETECTED) begin
      rep.status = vuc_pkg::ST_DETECTED;
    end else if (cap < held_q + 1) begin
      rep.status = (phase_q >= vuc_pkg::PH_SPEECH) ?
                   vuc_pkg::ST_FULL_SPEECH : vuc_pkg::ST_FULL_OTHER;
    end else begin
      prev = held_q;
      if (pcount_q < 32'hFFFF) pcount_q++;
      speech = preroll_ok_q && r.is_speech;
      case (phase_q)
        vuc_pkg::PH_WARMUP: begin
          if (pcount_q >= warmup_cfg) begin
            pcount_q = 0;
            phase_q = vuc_pkg::PH_SETUP;
          end
        end
        vuc_pkg::PH_SETUP: begin
          pcount_q = 0;
          phase_q = vuc_pkg::PH_SILENCE;
        end
        vuc_pkg::PH_SILENCE: begin
          if (!preroll_ok_q) begin
            held_q++;
            if (pcount_q >= preroll_cfg) preroll_ok_q = 1'b1;
          end else if (speech) begin
            pcount_q = 0;
            held_q++;
            phase_q = vuc_pkg::PH_PREDETECT;
          end
        end
        vuc_pkg::PH_PREDETECT: begin
          if (speech) begin
            held_q++;
            if (pcount_q >= decision_cfg) begin
              pcount_q = 0;
              phase_q = vuc_pkg::PH_SPEECH;
            end
          end else begin
            held_q = (held_q > pcount_q) ? held_q - pcount_q : 0;
            pcount_q = 0;
            phase_q = vuc_pkg::PH_SILENCE;
          end
        end
        vuc_pkg::PH_SPEECH: begin
          held_q++;
          if (!speech) begin
            pcount_q = 0;
            phase_q = vuc_pkg::PH_POSTDETECT;
          end
        end
        vuc_pkg::PH_POSTDETECT: begin
          held_q++;
          if (speech) begin
            pcount_q = 0;
            phase_q = vuc_pkg::PH_SPEECH;
          end else if (pcount_q >= hangover_cfg) begin
            pcount_q = 0;
            phase_q = vuc_pkg::PH_DETECTED;
          end
        end
        vuc_pkg::PH_DETECTED: ;
        default: begin
          pcount_q = 0;
          held_q = 0;
          phase_q = vuc_pkg::PH_WARMUP;
        end
      endcase
      if (prev + 1 == held_q) begin
        rep.buffer_action = vuc_pkg::ACT_STORE;
        rep.write_index = 10'(prev);
      end else if (phase_q == vuc_pkg::PH_SILENCE && prev >= held_q) begin
        shift = prev - held_q + 1;
        if (prev > shift) begin
          rep.buffer_action = vuc_pkg::ACT_SLIDE;
          rep.slide_frames = 11'(shift);
          rep.write_index = 10'(prev - shift);
        end
      end
      rep.status = (phase_q == vuc_pkg::PH_DETECTED) ? vuc_pkg::ST_DETECTED : vuc_pkg::ST_LISTEN;
    end
    rep.vad_phase = phase_q;
    rep.sound_frames = 11'(held_q);
    return rep;
  endfunction

  function automatic vuc_pkg::vuc_in_t next_frame(bit may_restart, bit speech_heavy);
    vuc_pkg::vuc_in_t r;
    int unsigned      cap;
    cap = (capacity_cfg > vuc_pkg::MAX_FRAMES_DEF) ? vuc_pkg::MAX_FRAMES_DEF : capacity_cfg;
    if (run_left == 0) begin
      run_val = !run_val;
      if (speech_heavy) run_left = run_val ? $urandom_range(10, 60) : $urandom_range(1, 3);
      else run_left = $urandom_range(1, 12);
    end
    run_left--;
    r.is_speech = ($urandom_range(0, 9) == 0) ? !run_val : run_val;
    r.mode = may_restart && ((phase_q == vuc_pkg::PH_DETECTED && $urandom_range(0, 3) == 0) ||
                             (cap < held_q + 1 && $urandom_range(0, 7) == 0) ||
                             $urandom_range(0, 79) == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic close_cfg();
    if (cfg_we) cfg_we <= 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      vuc_pkg::CFG_WARMUP:   warmup_cfg = 32'(val);
      vuc_pkg::CFG_PREROLL:  preroll_cfg = 32'(val);
      vuc_pkg::CFG_DECISION: decision_cfg = 32'(val);
      vuc_pkg::CFG_HANGOVER: hangover_cfg = 32'(val);
      vuc_pkg::CFG_CAPACITY: capacity_cfg = 32'(val[10:0]);
      default: ;
    endcase
  endtask

  task automatic load_config(logic [15:0] w, logic [15:0] p, logic [15:0] d,
                             logic [15:0] h, logic [15:0] c);
    write_reg(vuc_pkg::CFG_WARMUP, w);
    write_reg(vuc_pkg::CFG_PREROLL, p);
    write_reg(vuc_pkg::CFG_DECISION, d);
    write_reg(vuc_pkg::CFG_HANGOVER, h);
    write_reg(vuc_pkg::CFG_CAPACITY, c);
  endtask

  // drop valid and hold until every report is back
  task automatic settle();
    close_cfg();
    in_if.valid <= 1'b0;
    while (frame_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_request(vuc_pkg::vuc_in_t r, int gap, bit typed,
                              vuc_pkg::vuc_out_t want);
    vuc_pkg::vuc_out_t guess;
    close_cfg();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    guess = capture_step(r);
    frame_reports.push_back(typed ? want : guess);
  endtask

  task automatic run_phase(int count, int send_idle, int recv_stall, bit may_restart,
                           bit speech_heavy);
    vuc_pkg::vuc_in_t r;
    int               gap;
    stall_pct = recv_stall;
    for (int k = 0; k < count; k++) begin
      if (k == 0) r = $urandom_range(0, 1) ? RESTART_VOICE : RESTART_QUIET;
      else r = next_frame(may_restart, speech_heavy);
      gap = 0;
      while ($urandom_range(0, 99) < send_idle) gap++;
      send_request(r, gap, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    vuc_pkg::vuc_out_t want;
    vuc_pkg::vuc_out_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (frame_reports.size() == 0) begin
        $error("unexpected report: phase %0d status %0d", got.vad_phase, got.status);
        mismatches++;
      end else begin
        want = frame_reports.pop_front();
        check_field("vad_phase", 16'(want.vad_phase), 16'(got.vad_phase));
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("sound_frames", 16'(want.sound_frames), 16'(got.sound_frames));
        check_field("buffer_action", 16'(want.buffer_action), 16'(got.buffer_action));
        check_field("write_index", 16'(want.write_index), 16'(got.write_index));
        check_field("slide_frames", 16'(want.slide_frames), 16'(got.slide_frames));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] cap_pick;
    in_if.valid = 1'b0;
    in_if.payload = FRAME_QUIET;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = vuc_pkg::CFG_WARMUP;
    cfg_wdata = 16'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].reg_wr) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_request(plan[i].req, 0, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < 9; p++) begin
      settle();
      case ($urandom_range(0, 4))
        0: cap_pick = 16'($urandom_range(0, 2));
        1: cap_pick = 16'($urandom_range(3, 30));
        2: cap_pick = 16'($urandom_range(100, 1023));
        3: cap_pick = 16'd1024;
        default: cap_pick = 16'($urandom_range(1025, 2047));
      endcase
      if (p == 4) load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2047);
      else if (p == 6) load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd1024);
      else load_config(16'($urandom_range(0, 3)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(0, 5)), 16'($urandom_range(0, 8)), cap_pick);
      if (p == 2) hold_req++;
      run_phase(16, send_idle_pct[p % 4], recv_stall_pct[p % 4], 1'b1, 1'b0);
    end

    // fill the whole buffer through one long utterance
    settle();
    load_config(16'd0, 16'd3, 16'd2, 16'hFFFF, 16'd2047);
    run_phase(1080, 0, 0, 1'b0, 1'b1);

    settle();
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/vuc_pkg.sv
rtl/vuc_stream_if.sv
rtl/vad_utterance_capture_fsm.sv
verif/testbench.sv
